### rtl/fjps_pkg.sv
`timescale 1ns / 1ps
package fjps_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2
  } fjps_kind_t;

  typedef struct packed {
    logic inside_name;
    logic inside_value;
    logic await_name;
    logic await_value;
    logic name_has_chars;
  } flags_t;

  localparam flags_t FLAGS_RESET = '{
    inside_name:    1'b0,
    inside_value:   1'b0,
    await_name:     1'b1,
    await_value:    1'b0,
    name_has_chars: 1'b0
  };

  // one queue entry: first result, plus an optional end of pair after it
  typedef struct packed {
    fjps_kind_t kind;
    logic [7:0] ch;
    logic       two;
  } entry_t;

endpackage

### rtl/fjps_front.sv
`timescale 1ns / 1ps
module fjps_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  output logic            push,
  output fjps_pkg::entry_t entry
);
  import fjps_pkg::*;

  flags_t flags_r, flags_nxt;
  logic   has0;
  logic   tail_end;
  fjps_kind_t kind0;
  logic [7:0] ch0;
  logic   is_dig;

  assign is_dig = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);

  always_comb begin
    flags_nxt = flags_r;
    has0      = 1'b0;
    kind0     = KIND_END;
    ch0       = 8'h00;
    tail_end  = 1'b0;
    if (in_byte == CH_QUOTE) begin
      if (flags_nxt.await_name) begin
        if (flags_nxt.inside_name) begin
          flags_nxt.inside_name = 1'b0;
          flags_nxt.await_name  = 1'b0;
          flags_nxt.await_value = 1'b1;
        end else begin
          flags_nxt.inside_name = 1'b1;
        end
      end else if (flags_nxt.await_value) begin
        if (flags_nxt.inside_value) begin
          has0 = 1'b1;
          flags_nxt.inside_value   = 1'b0;
          flags_nxt.await_name     = 1'b1;
          flags_nxt.await_value    = 1'b0;
          flags_nxt.name_has_chars = 1'b0;
        end else begin
          flags_nxt.inside_value = 1'b1;
        end
      end
    end else if (flags_nxt.inside_name) begin
      has0  = 1'b1;
      kind0 = KIND_NAME;
      ch0   = in_byte;
      flags_nxt.name_has_chars = 1'b1;
    end else begin
      // a digit right after a name opens an unquoted number
      if (flags_nxt.await_value && !flags_nxt.inside_value && is_dig) begin
        flags_nxt.inside_value = 1'b1;
        flags_nxt.await_value  = 1'b0;
      end
      if (flags_nxt.inside_value) begin
        if (flags_nxt.await_value || is_dig || in_byte == CH_MINUS ||
            in_byte == CH_DOT) begin
          has0  = 1'b1;
          kind0 = KIND_VALUE;
          ch0   = in_byte;
        end else if (in_byte == CH_COMMA) begin
          has0 = 1'b1;
          flags_nxt.inside_value   = 1'b0;
          flags_nxt.await_name     = 1'b1;
          flags_nxt.await_value    = 1'b0;
          flags_nxt.name_has_chars = 1'b0;
        end
      end
    end
    if (in_last) begin
      tail_end  = flags_nxt.name_has_chars;
      flags_nxt = FLAGS_RESET;
    end
  end

  always_comb begin
    if (has0) begin
      entry.kind = kind0;
      entry.ch   = ch0;
      entry.two  = tail_end;
    end else begin
      entry.kind = KIND_END;
      entry.ch   = 8'h00;
      entry.two  = 1'b0;
    end
    push = accept && (has0 || tail_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= FLAGS_RESET;
    end else if (accept) begin
      flags_r <= flags_nxt;
    end
  end

endmodule

### rtl/fjps_queue.sv
`timescale 1ns / 1ps
module fjps_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fjps_pkg::entry_t push_entry,
  input  logic             pop,
  output fjps_pkg::entry_t head,
  output logic             empty,
  output logic             full
);
  import fjps_pkg::*;

  entry_t           slot_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]   count_r, count_nxt;
  logic             do_pop;

  assign empty  = (count_r == '0);
  assign full   = (count_r == QCW'(QDEPTH));
  assign head   = slot_r[rd_ptr_r];
  assign do_pop = pop && !empty;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

### rtl/fjps_back.sv
`timescale 1ns / 1ps
module fjps_back (
  input  logic             clk,
  input  logic             rst_n,
  input  fjps_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);
  import fjps_pkg::*;

  entry_t hold_r;
  logic   hold_v_r;
  logic   second_r;
  logic   fire;
  logic   load;

  assign fire = hold_v_r && out_tready;
  // take the next entry once the held one has given its last word
  assign load = !hold_v_r || (fire && (second_r || !hold_r.two));
  assign pop  = load && !empty;

  assign out_tvalid = hold_v_r;
  assign out_tdata  = second_r ? 8'h00 : hold_r.ch;
  assign out_tuser  = second_r ? KIND_END : hold_r.kind;
  assign out_tlast  = second_r || !hold_r.two;

  always_ff @(posedge clk) begin
    if (pop) begin
      hold_r <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      second_r <= 1'b0;
    end else if (load) begin
      hold_v_r <= !empty;
      second_r <= 1'b0;
    end else if (fire) begin
      second_r <= 1'b1;
    end
  end

endmodule

### rtl/flat_json_pair_scanner_top.sv
`timescale 1ns / 1ps
// Scans flat JSON-like text one byte per word and streams the characters of
// each name (tuser 0) and value (tuser 1), then an end-of-pair word (tuser 2,
// tdata zero); tlast marks the last result word caused by an input byte. A
// new byte is taken every cycle while the four-entry queue between the byte
// classifier and the output serializer has room; a byte yields up to two result
// words, and the output drains one word per cycle while out_tready is high, so
// the sustained rate is one byte per cycle unless bytes produce two words in a row.
module flat_json_pair_scanner_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic [1:0] out_tuser,  // [1:0] out_kind
  output logic       out_tlast
);
  import fjps_pkg::*;

  logic   push, pop, q_empty, q_full;
  entry_t push_entry, head;

  assign in_tready = !q_full;

  fjps_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_tvalid && in_tready),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .push    (push),
    .entry   (push_entry)
  );

  fjps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  fjps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### rtl/fjps_checker.sv
`timescale 1ns / 1ps
module fjps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);
  import fjps_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("out word changed while stalled");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_NAME || out_tuser == KIND_VALUE ||
                    out_tuser == KIND_END))
    else $error("undefined out kind");

  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_END |-> out_tdata == 8'h00)
    else $error("end of pair with nonzero char");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("out valid or in not ready right after reset");

endmodule

bind flat_json_pair_scanner_top fjps_checker u_fjps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
